// File: rtl/btpp_pkg.sv
// Shared types, codes and constants of the bike telemetry packet parser.
package btpp_pkg;

  // Packet geometry.
  localparam int PKT_LEN = 13;
  localparam int CNT_W   = $clog2(PKT_LEN + 1);

  // Depth of the record queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Packet status codes.
  localparam logic [2:0] ST_SHORT    = 3'd0;
  localparam logic [2:0] ST_LED      = 3'd1;
  localparam logic [2:0] ST_BAD_SYNC = 3'd2;
  localparam logic [2:0] ST_BAD_SUM  = 3'd3;
  localparam logic [2:0] ST_BAD_END  = 3'd4;
  localparam logic [2:0] ST_ACCEPTED = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_DATA_SYNC   = 2'd0;
  localparam logic [1:0] REG_LED_SYNC    = 2'd1;
  localparam logic [1:0] REG_END_BYTE    = 2'd2;
  localparam logic [1:0] REG_POWER_COEFF = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] DATA_SYNC_RST   = 8'd85;
  localparam logic [7:0] LED_SYNC_RST    = 8'd170;
  localparam logic [7:0] END_BYTE_RST    = 8'd63;
  localparam logic [9:0] POWER_COEFF_RST = 10'd456;

  // Power is rpm * resistance * coeff / 100, done as a shift by two and a divide by 25.
  // The divide by 25 multiplies by ceil(2^35 / 25) and keeps the bits above 35; this is
  // exact for every dividend below 2^32.
  localparam int                 PROD1_W     = 24;
  localparam int                 PROD2_W     = 34;
  localparam int                 QUO_W       = PROD2_W - 2;
  localparam int                 RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP_25    = 31'd1374389535;
  localparam int                 RECIP_SHIFT = 35;
  localparam int                 MULQ_W      = QUO_W + RECIP_W;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [7:0] data_sync;
    logic [7:0] led_sync;
    logic [7:0] end_byte;
    logic [9:0] power_coeff;
  } cfg_t;

  // One classified packet, handed from the front to the back part.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] speed;
    logic [7:0]  res;
    logic [15:0] rpm;
  } pkt_rec_t;

endpackage

// File: rtl/btpp_if.sv
// Handshake channels of the bike telemetry packet parser.
interface btpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface btpp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] speed_tenths;
  logic [7:0]  resistance;
  logic [15:0] cadence_rpm;
  logic [27:0] power_centiwatts;
  logic        telemetry_valid;

  modport source (output valid, output status, output speed_tenths, output resistance,
                  output cadence_rpm, output power_centiwatts, output telemetry_valid,
                  input ready);
  modport sink (input valid, input status, input speed_tenths, input resistance,
                input cadence_rpm, input power_centiwatts, input telemetry_valid,
                output ready);
endinterface

// File: rtl/btpp_front.sv
// Front part: takes received bytes, captures packet fields and classifies each chunk.
module btpp_front (
  input  logic               clk,
  input  logic               rst_n,
  btpp_in_if.sink            in_ch,
  input  btpp_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_push,
  output btpp_pkg::pkt_rec_t q_data
);
  import btpp_pkg::*;

  // Byte positions inside a packet.
  localparam logic [CNT_W-1:0] POS_SYNC     = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_SUM_LO   = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_SUM_HI   = CNT_W'(10);
  localparam logic [CNT_W-1:0] POS_SPEED_LO = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_SPEED_HI = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_RES      = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_RPM_LO   = CNT_W'(8);
  localparam logic [CNT_W-1:0] POS_RPM_HI   = CNT_W'(9);
  localparam logic [CNT_W-1:0] POS_CHK      = CNT_W'(11);
  localparam logic [CNT_W-1:0] POS_TAIL     = CNT_W'(12);
  localparam logic [CNT_W-1:0] LEN_C        = CNT_W'(PKT_LEN);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic [7:0]       tail_r, tail_nxt;
  logic [15:0]      speed_r, speed_nxt;
  logic [7:0]       res_r, res_nxt;
  logic [15:0]      rpm_r, rpm_nxt;
  logic             accept;
  logic [2:0]       status;

  // A byte is taken whenever the queue has room for a record.
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Field capture, classification at the end of a chunk, and clearing after it.
  always_comb begin
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    sum_nxt   = sum_r;
    chk_nxt   = chk_r;
    tail_nxt  = tail_r;
    speed_nxt = speed_r;
    res_nxt   = res_r;
    rpm_nxt   = rpm_r;

    if (accept && (cnt_r < LEN_C)) begin
      case (cnt_r)
        POS_SYNC:     first_nxt = in_ch.rx_byte;
        POS_SPEED_LO: speed_nxt[7:0] = in_ch.rx_byte;
        POS_SPEED_HI: speed_nxt[15:8] = in_ch.rx_byte;
        POS_RES:      res_nxt = in_ch.rx_byte;
        POS_RPM_LO:   rpm_nxt[7:0] = in_ch.rx_byte;
        POS_RPM_HI:   rpm_nxt[15:8] = in_ch.rx_byte;
        POS_CHK:      chk_nxt = in_ch.rx_byte;
        POS_TAIL:     tail_nxt = in_ch.rx_byte;
        default: ;
      endcase
      if (cnt_r inside {[POS_SUM_LO:POS_SUM_HI]}) begin
        sum_nxt = sum_r + in_ch.rx_byte;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    // The checks run in a fixed order; the LED sync wins over the data sync.
    if (cnt_nxt < LEN_C) begin
      status = ST_SHORT;
    end else if (first_nxt == cfg.led_sync) begin
      status = ST_LED;
    end else if (first_nxt != cfg.data_sync) begin
      status = ST_BAD_SYNC;
    end else if (sum_nxt != chk_nxt) begin
      status = ST_BAD_SUM;
    end else if (tail_nxt != cfg.end_byte) begin
      status = ST_BAD_END;
    end else begin
      status = ST_ACCEPTED;
    end

    q_push        = accept && in_ch.chunk_end;
    q_data.status = status;
    q_data.speed  = speed_nxt;
    q_data.res    = res_nxt;
    q_data.rpm    = rpm_nxt;

    if (q_push) begin
      cnt_nxt   = '0;
      first_nxt = '0;
      sum_nxt   = '0;
      chk_nxt   = '0;
      tail_nxt  = '0;
      speed_nxt = '0;
      res_nxt   = '0;
      rpm_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      first_r <= '0;
      sum_r   <= '0;
      chk_r   <= '0;
      tail_r  <= '0;
      speed_r <= '0;
      res_r   <= '0;
      rpm_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      sum_r   <= sum_nxt;
      chk_r   <= chk_nxt;
      tail_r  <= tail_nxt;
      speed_r <= speed_nxt;
      res_r   <= res_nxt;
      rpm_r   <= rpm_nxt;
    end
  end

endmodule

// File: rtl/btpp_fifo.sv
// Short record queue between the front and back parts.
module btpp_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  btpp_pkg::pkt_rec_t wr_data,
  input  logic               pop,
  output btpp_pkg::pkt_rec_t rd_data,
  output logic               full,
  output logic               empty
);
  import btpp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  pkt_rec_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: rtl/btpp_back.sv
// Back part: applies accepted packets, computes power and presents the result word.
module btpp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  btpp_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  btpp_pkg::pkt_rec_t q_data,
  output logic               q_pop,
  btpp_out_if.source         out_ch
);
  import btpp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_MUL2 = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  pkt_rec_t           rec_r, rec_nxt;
  logic [PROD1_W-1:0] prod1_r, prod1_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [27:0]        power_r, power_nxt;
  logic [PROD2_W-1:0] prod2;
  logic [MULQ_W-1:0]  mulq;
  logic [2:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        held_speed_r, held_speed_nxt;
  logic [7:0]         held_res_r, held_res_nxt;
  logic [15:0]        held_rpm_r, held_rpm_nxt;
  logic [27:0]        held_power_r, held_power_nxt;
  logic               valid_flag_r, valid_flag_nxt;
  logic               out_free;

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.speed_tenths     = held_speed_r;
  assign out_ch.resistance       = held_res_r;
  assign out_ch.cadence_rpm      = held_rpm_r;
  assign out_ch.power_centiwatts = held_power_r;
  assign out_ch.telemetry_valid  = valid_flag_r;

  // Second product, and the reciprocal product that divides by 25.
  assign prod2 = PROD2_W'(prod1_r) * PROD2_W'(cfg.power_coeff);
  assign mulq  = MULQ_W'(quo_r) * MULQ_W'(RECIP_25);

  // Sequencer: pop a record, then for an accepted packet multiply twice and divide by 100.
  always_comb begin
    state_nxt      = state_r;
    rec_nxt        = rec_r;
    prod1_nxt      = prod1_r;
    quo_nxt        = quo_r;
    power_nxt      = power_r;
    status_nxt     = status_r;
    held_speed_nxt = held_speed_r;
    held_res_nxt   = held_res_r;
    held_rpm_nxt   = held_rpm_r;
    held_power_nxt = held_power_r;
    valid_flag_nxt = valid_flag_r;
    q_pop          = 1'b0;

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop   = 1'b1;
          rec_nxt = q_data;
          if (q_data.status == ST_ACCEPTED) begin
            state_nxt = S_MUL1;
          end else begin
            status_nxt    = q_data.status;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_MUL1: begin
        prod1_nxt = PROD1_W'(rec_r.rpm) * PROD1_W'(rec_r.res);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        // Dropping the two low bits divides by four exactly under truncation.
        quo_nxt   = prod2[PROD2_W-1:2];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        power_nxt = mulq[RECIP_SHIFT +: 28];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        held_speed_nxt = rec_r.speed;
        held_res_nxt   = rec_r.res;
        held_rpm_nxt   = rec_r.rpm;
        held_power_nxt = power_r;
        valid_flag_nxt = 1'b1;
        status_nxt     = ST_ACCEPTED;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      held_speed_r <= '0;
      held_res_r   <= '0;
      held_rpm_r   <= '0;
      held_power_r <= '0;
      valid_flag_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      held_speed_r <= held_speed_nxt;
      held_res_r   <= held_res_nxt;
      held_rpm_r   <= held_rpm_nxt;
      held_power_r <= held_power_nxt;
      valid_flag_r <= valid_flag_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rec_r    <= rec_nxt;
    prod1_r  <= prod1_nxt;
    quo_r    <= quo_nxt;
    power_r  <= power_nxt;
    status_r <= status_nxt;
  end

endmodule

// File: rtl/bike_telemetry_packet_parser.sv
// Top level of the bike telemetry packet parser with its configuration registers.
// The parser takes one received byte per word on in_ch, the last byte of a chunk marked by
// chunk_end, and gives one result word on out_ch for each chunk: a status (short, LED packet,
// bad sync, bad checksum, bad end byte, accepted) together with the held speed, resistance,
// cadence, power and the sticky telemetry_valid flag. The front part takes a byte every cycle
// while its two-entry record queue has room. The back part pops a record only while its result
// register is free; a rejected packet needs only the pop, and an accepted one goes through the
// pop, two multiplies, a reciprocal multiply for the divide by 25 and the update of the held
// values.
// Registers are written over the APB-style port at byte addresses 0, 4, 8 and 12.
module bike_telemetry_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  btpp_in_if.sink     in_ch,
  btpp_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import btpp_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [1:0] reg_idx;
  logic       cfg_wr;
  logic       q_push, q_pop, q_full, q_empty;
  pkt_rec_t   q_wr_data, q_rd_data;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_DATA_SYNC:   cfg_nxt.data_sync = cfg_pwdata[7:0];
        REG_LED_SYNC:    cfg_nxt.led_sync = cfg_pwdata[7:0];
        REG_END_BYTE:    cfg_nxt.end_byte = cfg_pwdata[7:0];
        REG_POWER_COEFF: cfg_nxt.power_coeff = cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    case (reg_idx)
      REG_DATA_SYNC:   cfg_prdata = {24'd0, cfg_r.data_sync};
      REG_LED_SYNC:    cfg_prdata = {24'd0, cfg_r.led_sync};
      REG_END_BYTE:    cfg_prdata = {24'd0, cfg_r.end_byte};
      REG_POWER_COEFF: cfg_prdata = {22'd0, cfg_r.power_coeff};
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_sync   <= DATA_SYNC_RST;
      cfg_r.led_sync    <= LED_SYNC_RST;
      cfg_r.end_byte    <= END_BYTE_RST;
      cfg_r.power_coeff <= POWER_COEFF_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  btpp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  btpp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  btpp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
